// ===== rtl/assert_macros.svh =====
// assertion macros for the rtl, compiled out when NO_ASSERTIONS is set
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// condition holds on every clock out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/hahe_pkg.sv =====
// types and constants of the html anchor href extractor
package hahe_pkg;

    localparam int WIN_DEPTH = 5;
    localparam int FILL_W    = 3;
    localparam int MAX_LINKS = 128;
    localparam int LINK_NUM_W = 7;

    // result queue
    localparam int RQ_DEPTH = 4;
    localparam int RQ_PTR_W = 2;
    localparam int RQ_CNT_W = 3;

    // skip count loaded at the 'h' of href=: r, e, f and = are skipped, an opening quote dropped
    localparam logic [2:0] SKIP_HREF = 3'd5;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_SP     = 8'h20;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_CASE   = 8'h20;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CH_H      = 8'h68;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_E      = 8'h65;
    localparam logic [7:0] CH_F      = 8'h66;

    typedef struct packed {
        logic [7:0] page_byte;
        logic       page_last;
    } t_page_item;

    typedef struct packed {
        logic [LINK_NUM_W-1:0] link_number;
        logic [7:0]            link_byte;
        logic                  byte_valid;
        logic                  link_end;
        logic                  page_done;
    } t_link_item;

endpackage

// ===== rtl/html_anchor_href_extractor.sv =====
// Html anchor href extractor: one page byte in, link bytes and link/page markers out.
// Results are written into the result queue; the output shows its head entry.
// Throughput: one byte per cycle while the result queue has room; after a page-end byte
// the input is held while the window unit flushes, one position per cycle with queue room.
// The four-entry result queue holds the input while fewer than two entries are free.
// Reset (i_rst_n low, synchronous) clears the window, scan state and result queue.
`include "assert_macros.svh"

module html_anchor_href_extractor
    import hahe_pkg::*;
#(
    parameter int MAX_LINK_LEN = 128
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_page_item i_in_data,
    output logic       o_in_stall,
    output logic       o_out_valid,
    output t_link_item o_out_data,
    input  logic       i_out_stall
);

    localparam int LEN_W = $clog2(MAX_LINK_LEN);
    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MAX_LINK_LEN - 1);
    localparam logic [LINK_NUM_W-1:0] LINK_LIMIT = LINK_NUM_W'(MAX_LINKS - 1);

    function automatic logic is_quote(input logic [7:0] c);
        is_quote = (c == CH_DQUOTE) || (c == CH_SQUOTE);
    endfunction

    // case-insensitive letter match, lower holds the lower-case code
    function automatic logic ci_eq(input logic [7:0] c, input logic [7:0] lower);
        ci_eq = ((c | CH_CASE) == lower);
    endfunction

    function automatic t_link_item make_res(input logic [LINK_NUM_W-1:0] num,
                                            input logic [7:0] b, input logic bv,
                                            input logic le, input logic pd);
        t_link_item r;
        r.link_number = num;
        r.link_byte   = b;
        r.byte_valid  = bv;
        r.link_end    = le;
        r.page_done   = pd;
        make_res = r;
    endfunction

    // scan state
    logic [7:0]            r_win [WIN_DEPTH];
    logic [7:0]            n_win [WIN_DEPTH];
    logic [FILL_W-1:0]     r_fill, n_fill;
    logic                  r_ia, n_ia;
    logic                  r_cap, n_cap;
    logic [2:0]            r_skip, n_skip;
    logic [LEN_W-1:0]      r_cil, n_cil;
    logic [LINK_NUM_W-1:0] r_links, n_links;
    logic                  r_stop, n_stop;
    logic                  r_flush, n_flush;

    // result queue
    t_link_item            r_mem [RQ_DEPTH];
    logic [RQ_PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [RQ_PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [RQ_CNT_W-1:0]   r_count, n_count;

    logic                  in_accept;
    logic                  in_end;
    logic                  flush_step;
    logic                  do_exam;
    logic                  pop;
    logic [7:0]            exam_win [WIN_DEPTH];
    logic                  exam_go;
    logic                  anchor_now;
    logic [LEN_W-1:0]      cil_inc;
    logic [LINK_NUM_W-1:0] links_inc;
    logic                  push0, push1;
    t_link_item            res0, res1;

    assign o_in_stall  = r_flush || (r_count > RQ_CNT_W'(RQ_DEPTH - 2));
    assign in_accept   = i_in_valid && !o_in_stall;
    assign in_end      = (i_in_data.page_byte == CH_NUL) || i_in_data.page_last;
    assign flush_step  = r_flush && (r_count <= RQ_CNT_W'(RQ_DEPTH - 2));
    assign do_exam     = (in_accept && !in_end && (r_fill == FILL_W'(WIN_DEPTH - 1)))
                       || (flush_step && (r_fill != '0));
    assign o_out_valid = (r_count != '0);
    assign o_out_data  = r_mem[r_rd_ptr];
    assign pop         = o_out_valid && !i_out_stall;
    assign cil_inc     = r_cil + LEN_W'(1);
    assign links_inc   = r_links + LINK_NUM_W'(1);

    // examined view: while streaming, the new byte is the last lookahead position
    always_comb begin
        for (int k = 0; k < WIN_DEPTH - 1; k++) begin
            exam_win[k] = r_win[k];
        end
        exam_win[WIN_DEPTH-1] = r_flush ? r_win[WIN_DEPTH-1] : i_in_data.page_byte;
    end

    always_comb begin
        n_win    = r_win;
        n_fill   = r_fill;
        n_ia     = r_ia;
        n_cap    = r_cap;
        n_skip   = r_skip;
        n_cil    = r_cil;
        n_links  = r_links;
        n_stop   = r_stop;
        n_flush  = r_flush;
        push0    = 1'b0;
        push1    = 1'b0;
        res0     = make_res(r_links, CH_NUL, 1'b0, 1'b1, 1'b0);
        res1     = make_res(r_links, CH_NUL, 1'b0, 1'b1, 1'b0);
        exam_go  = 1'b0;
        anchor_now = r_ia;

        // examine the byte leaving the window
        if (do_exam && !r_stop) begin
            if (r_skip > 3'd1) begin
                n_skip = r_skip - 3'd1;
            end else begin
                exam_go = 1'b1;
                if (r_skip == 3'd1) begin
                    n_skip = 3'd0;
                    if (!r_cap || is_quote(exam_win[0])) begin
                        exam_go = 1'b0;
                    end
                end
                if (exam_go) begin
                    if (r_cap) begin
                        if (is_quote(exam_win[0]) || (exam_win[0] == CH_GT) ||
                            (exam_win[0] == CH_SP)) begin
                            push0   = 1'b1;
                            n_cap   = 1'b0;
                            n_cil   = '0;
                            n_links = links_inc;
                            n_stop  = (links_inc >= LINK_LIMIT);
                        end else begin
                            push0 = 1'b1;
                            res0  = make_res(r_links, exam_win[0], 1'b1, 1'b0, 1'b0);
                            n_cil = cil_inc;
                            // truncation: close the link and drop the next byte
                            if (cil_inc >= LEN_LIMIT) begin
                                push1   = 1'b1;
                                n_cap   = 1'b0;
                                n_cil   = '0;
                                n_links = links_inc;
                                n_stop  = (links_inc >= LINK_LIMIT);
                                n_skip  = 3'd1;
                            end
                        end
                    end else begin
                        if ((exam_win[0] == CH_LT) && !r_ia &&
                            (ci_eq(exam_win[1], CH_A) ||
                             ((exam_win[1] == CH_SP) && ci_eq(exam_win[2], CH_A)))) begin
                            anchor_now = 1'b1;
                        end
                        if ((exam_win[0] == CH_LT) && (exam_win[1] == CH_SLASH) &&
                            ci_eq(exam_win[2], CH_A) && (exam_win[3] == CH_GT)) begin
                            anchor_now = 1'b0;
                        end
                        n_ia = anchor_now;
                        if (anchor_now && ci_eq(exam_win[0], CH_H) &&
                            ci_eq(exam_win[1], CH_R) && ci_eq(exam_win[2], CH_E) &&
                            ci_eq(exam_win[3], CH_F) && (exam_win[4] == CH_EQ)) begin
                            n_cap  = 1'b1;
                            n_cil  = '0;
                            n_skip = SKIP_HREF;
                        end
                    end
                end
            end
        end

        // window movement
        if (in_accept) begin
            if (!in_end && (r_fill == FILL_W'(WIN_DEPTH - 1))) begin
                for (int k = 0; k < WIN_DEPTH - 1; k++) begin
                    n_win[k] = exam_win[k+1];
                end
                n_win[WIN_DEPTH-1] = CH_NUL;
            end else if (i_in_data.page_byte != CH_NUL) begin
                for (int k = 0; k < WIN_DEPTH; k++) begin
                    if (FILL_W'(k) == r_fill) begin
                        n_win[k] = i_in_data.page_byte;
                    end
                end
                n_fill = r_fill + FILL_W'(1);
            end
            if (in_end) begin
                n_flush = 1'b1;
            end
        end else if (flush_step) begin
            if (r_fill != '0) begin
                for (int k = 0; k < WIN_DEPTH - 1; k++) begin
                    n_win[k] = r_win[k+1];
                end
                n_win[WIN_DEPTH-1] = CH_NUL;
                n_fill = r_fill - FILL_W'(1);
            end else begin
                // page end: close an open link, report, then start over
                push0 = 1'b1;
                if (r_cap && !r_stop) begin
                    push1 = 1'b1;
                    res1  = make_res(links_inc, CH_NUL, 1'b0, 1'b0, 1'b1);
                end else begin
                    res0  = make_res(r_links, CH_NUL, 1'b0, 1'b0, 1'b1);
                end
                n_ia    = 1'b0;
                n_cap   = 1'b0;
                n_skip  = 3'd0;
                n_cil   = '0;
                n_links = '0;
                n_stop  = 1'b0;
                n_flush = 1'b0;
            end
        end
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr + RQ_PTR_W'(push0) + RQ_PTR_W'(push1);
        n_rd_ptr = r_rd_ptr + RQ_PTR_W'(pop);
        n_count  = r_count + RQ_CNT_W'(push0) + RQ_CNT_W'(push1) - RQ_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WIN_DEPTH; k++) begin
                r_win[k] <= CH_NUL;
            end
            r_fill   <= '0;
            r_ia     <= 1'b0;
            r_cap    <= 1'b0;
            r_skip   <= 3'd0;
            r_cil    <= '0;
            r_links  <= '0;
            r_stop   <= 1'b0;
            r_flush  <= 1'b0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_win    <= n_win;
            r_fill   <= n_fill;
            r_ia     <= n_ia;
            r_cap    <= n_cap;
            r_skip   <= n_skip;
            r_cil    <= n_cil;
            r_links  <= n_links;
            r_stop   <= n_stop;
            r_flush  <= n_flush;
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // result queue storage, up to two writes per cycle
    always_ff @(posedge i_clk) begin
        if (push0) begin
            r_mem[r_wr_ptr] <= res0;
        end
        if (push1) begin
            r_mem[r_wr_ptr + RQ_PTR_W'(1)] <= res1;
        end
    end

    `ASSERT_ALWAYS(a_rq_no_overflow, i_clk, i_rst_n, r_count <= RQ_CNT_W'(RQ_DEPTH), "result queue overflow")
    `ASSERT_ALWAYS(a_fill_in_range, i_clk, i_rst_n, r_fill <= FILL_W'(WIN_DEPTH), "window fill out of range")
    `ASSERT_IMPLY(a_idle_len_zero, i_clk, i_rst_n, !r_cap, r_cil == '0, "link length set while not capturing")
    `ASSERT_IMPLY(a_stop_no_cap, i_clk, i_rst_n, r_stop, !r_cap, "capturing after link limit")
    `ASSERT_NEXT(a_flush_ends, i_clk, i_rst_n, flush_step && (r_fill == '0), !r_flush, "page flush did not finish")
    `ASSERT_IMPLY(a_out_one_kind, i_clk, i_rst_n, o_out_valid, $onehot({o_out_data.byte_valid, o_out_data.link_end, o_out_data.page_done}), "result carries not exactly one kind")

endmodule

// ===== tb/html_anchor_href_extractor_test.sv =====
// self-checking testbench of the html anchor href extractor
`timescale 1ns / 100ps

module html_anchor_href_extractor_test;
    import hahe_pkg::*;

    localparam int LINK_LEN_LIMIT = 128;
    localparam int MAX_RESULTS    = 7;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int ERR_PRINT_MAX  = 100;
    localparam int RANDOM_ITEMS   = 180;

    typedef struct packed {
        logic       drain;
        t_page_item item;
    } t_page_stim;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    t_page_item in_data   = '0;
    logic       in_stall;
    logic       out_valid;
    t_link_item out_data;
    logic       out_stall = 1'b0;

    t_page_stim page_stim_q[$];
    t_link_item pending_links[$];
    int         total_items = 0;
    int         accepted    = 0;
    int         err_count   = 0;
    int         cycles      = 0;

    // scan state mirrored from the block
    logic [7:0] look [WIN_DEPTH];
    logic [2:0] look_fill;
    logic       in_anchor;
    logic       capturing;
    logic [2:0] skip_cnt;
    logic [6:0] link_len;
    logic [6:0] links_done;
    logic       scan_halted;
    int         results_this_byte;

    html_anchor_href_extractor #(
        .MAX_LINK_LEN(LINK_LEN_LIMIT)
    ) i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .i_in_data  (in_data),
        .o_in_stall (in_stall),
        .o_out_valid(out_valid),
        .o_out_data (out_data),
        .i_out_stall(out_stall)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("html_anchor_href_extractor verification failed");
            $finish;
        end
    end

    task automatic flag_error(string msg);
        if (err_count < ERR_PRINT_MAX)
            $display("%0t error: %s", $time, msg);
        err_count++;
    endtask

    // ---------------- link prediction ----------------

    task automatic reset_scan();
        for (int k = 0; k < WIN_DEPTH; k++)
            look[k] = CH_NUL;
        look_fill   = '0;
        in_anchor   = 1'b0;
        capturing   = 1'b0;
        skip_cnt    = '0;
        link_len    = '0;
        links_done  = '0;
        scan_halted = 1'b0;
    endtask

    function automatic logic [7:0] peek(int k);
        return (k < look_fill) ? look[k] : CH_NUL;
    endfunction

    function automatic logic is_quote(logic [7:0] c);
        return c == CH_SQUOTE || c == CH_DQUOTE;
    endfunction

    // letter match without regard to case
    function automatic logic is_letter(logic [7:0] c, logic [7:0] lower);
        return (c | CH_CASE) == lower;
    endfunction

    task automatic add_result(logic [7:0] b, logic bv, logic le, logic pd);
        t_link_item r;
        if (results_this_byte >= MAX_RESULTS)
            return;
        r.link_number = links_done;
        r.link_byte   = b;
        r.byte_valid  = bv;
        r.link_end    = le;
        r.page_done   = pd;
        pending_links.push_back(r);
        results_this_byte++;
    endtask

    task automatic close_link();
        add_result(CH_NUL, 1'b0, 1'b1, 1'b0);
        capturing  = 1'b0;
        link_len   = '0;
        links_done = links_done + 7'd1;
        if (links_done >= MAX_LINKS - 1)
            scan_halted = 1'b1;
    endtask

    task automatic examine_head();
        logic [7:0] c;
        c = peek(0);
        if (scan_halted)
            return;
        if (skip_cnt > 3'd1) begin
            skip_cnt = skip_cnt - 3'd1;
            return;
        end
        if (skip_cnt == 3'd1) begin
            skip_cnt = '0;
            // the opening quote of the link, or the byte after a truncation, is dropped
            if (!capturing || is_quote(c))
                return;
        end
        if (capturing) begin
            if (is_quote(c) || c == CH_GT || c == CH_SP) begin
                close_link();
                return;
            end
            add_result(c, 1'b1, 1'b0, 1'b0);
            link_len = link_len + 7'd1;
            if (link_len >= LINK_LEN_LIMIT - 1) begin
                close_link();
                skip_cnt = 3'd1;
            end
            return;
        end
        if (c == CH_LT && !in_anchor &&
            (is_letter(peek(1), CH_A) || (peek(1) == CH_SP && is_letter(peek(2), CH_A))))
            in_anchor = 1'b1;
        if (c == CH_LT && peek(1) == CH_SLASH && is_letter(peek(2), CH_A) && peek(3) == CH_GT)
            in_anchor = 1'b0;
        if (in_anchor && is_letter(c, CH_H) && is_letter(peek(1), CH_R) &&
            is_letter(peek(2), CH_E) && is_letter(peek(3), CH_F) && peek(4) == CH_EQ) begin
            capturing = 1'b1;
            link_len  = '0;
            skip_cnt  = SKIP_HREF;
        end
    endtask

    task automatic shift_look();
        for (int k = 0; k < WIN_DEPTH - 1; k++)
            look[k] = look[k + 1];
        look[WIN_DEPTH - 1] = CH_NUL;
        if (look_fill != 0)
            look_fill = look_fill - 3'd1;
    endtask

    task automatic scan_page_byte(t_page_item it);
        results_this_byte = 0;
        if (look_fill >= WIN_DEPTH) begin
            examine_head();
            shift_look();
        end
        if (it.page_byte != CH_NUL) begin
            look[look_fill] = it.page_byte;
            look_fill = look_fill + 3'd1;
        end
        if (it.page_byte == CH_NUL || it.page_last) begin
            // flush the window, then close the page
            while (look_fill != 0) begin
                examine_head();
                shift_look();
            end
            if (capturing && !scan_halted)
                close_link();
            add_result(CH_NUL, 1'b0, 1'b0, 1'b1);
            reset_scan();
        end else if (look_fill >= WIN_DEPTH) begin
            examine_head();
            shift_look();
        end
    endtask

    // ---------------- page generation ----------------

    task automatic push_byte(logic [7:0] b, logic last);
        t_page_stim s;
        s.drain          = 1'b0;
        s.item.page_byte = b;
        s.item.page_last = last;
        page_stim_q.push_back(s);
    endtask

    task automatic push_text(string txt);
        for (int i = 0; i < txt.len(); i++)
            push_byte(txt[i], 1'b0);
    endtask

    task automatic mark_last();
        t_page_stim s;
        s = page_stim_q.pop_back();
        s.item.page_last = 1'b1;
        page_stim_q.push_back(s);
    endtask

    function automatic logic [7:0] any_case(logic [7:0] c);
        return $urandom_range(0, 1) ? (c & ~CH_CASE) : c;
    endfunction

    function automatic logic [7:0] link_char();
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom_range(128, 255));
        return 8'($urandom_range(8'h21, 8'h7e));
    endfunction

    task automatic push_noise(int lo, int hi);
        repeat ($urandom_range(lo, hi)) begin
            if ($urandom_range(0, 29) == 0)
                push_byte(CH_NUL, 1'($urandom_range(0, 1)));
            else
                push_byte(8'($urandom_range(1, 255)), 1'b0);
        end
    endtask

    task automatic push_href();
        push_byte(any_case(CH_H), 1'b0);
        push_byte(any_case(CH_R), 1'b0);
        push_byte(any_case(CH_E), 1'b0);
        push_byte(any_case(CH_F), 1'b0);
        push_byte(CH_EQ, 1'b0);
    endtask

    task automatic push_anchor();
        case ($urandom_range(0, 5))
            0: push_text("<a ");
            1: push_text("<A ");
            2: push_text("< a ");
            3: push_text("< A ");
            4: push_text("<b ");
            default: push_text("<  a ");
        endcase
        if ($urandom_range(0, 3) == 0)
            push_noise(1, 4);
        push_href();
        case ($urandom_range(0, 2))
            0: push_byte(CH_SQUOTE, 1'b0);
            1: push_byte(CH_DQUOTE, 1'b0);
            default: ;
        endcase
        repeat ($urandom_range(0, 12))
            push_byte(link_char(), 1'b0);
        case ($urandom_range(0, 4))
            0: push_byte(CH_SQUOTE, 1'b0);
            1: push_byte(CH_DQUOTE, 1'b0);
            2: push_byte(CH_GT, 1'b0);
            3: push_byte(CH_SP, 1'b0);
            default: ;
        endcase
        if ($urandom_range(0, 1))
            push_text(" x>text");
        if ($urandom_range(0, 2) != 0)
            push_text($urandom_range(0, 1) ? "</a>" : "</A>");
    endtask

    task automatic push_page();
        if ($urandom_range(0, 19) == 0 && page_stim_q.size() != 0)
            page_stim_q[$].drain = 1'b1;
        repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: push_anchor();
                6: begin
                    push_href();
                    push_text("out ");
                end
                7: push_text("</a>");
                default: push_noise(1, 8);
            endcase
        end
        if ($urandom_range(0, 1))
            mark_last();
        else
            push_byte(CH_NUL, 1'($urandom_range(0, 1)));
    endtask

    // ---------------- handshakes ----------------

    function automatic int send_idle_pct();
        if (accepted < total_items / 3)
            return 26;
        if (accepted < 2 * total_items / 3)
            return 47;
        return 0;
    endfunction

    function automatic int recv_idle_pct();
        if (accepted < total_items / 3)
            return 47;
        if (accepted < 2 * total_items / 3)
            return 26;
        return 0;
    endfunction

    always @(posedge clk) begin : drive
        t_page_stim nxt;
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_data  <= '0;
            reset_scan();
        end else begin
            if (in_valid && !in_stall) begin
                scan_page_byte(in_data);
                accepted++;
            end
            if (!in_valid || !in_stall) begin
                // a drain item waits until every expected result has come
                if (page_stim_q.size() != 0 &&
                    !(page_stim_q[0].drain && pending_links.size() != 0) &&
                    $urandom_range(0, 99) >= send_idle_pct()) begin
                    nxt = page_stim_q.pop_front();
                    in_valid <= 1'b1;
                    in_data  <= nxt.item;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin : check
        t_link_item want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct());
            if (out_valid && !out_stall) begin
                if (pending_links.size() == 0) begin
                    flag_error($sformatf("unexpected result %h", out_data));
                end else begin
                    want = pending_links.pop_front();
                    if (out_data.link_number !== want.link_number)
                        flag_error($sformatf("link_number %0d, expected %0d",
                                             out_data.link_number, want.link_number));
                    if (out_data.link_byte !== want.link_byte)
                        flag_error($sformatf("link_byte %h, expected %h",
                                             out_data.link_byte, want.link_byte));
                    if (out_data.byte_valid !== want.byte_valid)
                        flag_error($sformatf("byte_valid %b, expected %b",
                                             out_data.byte_valid, want.byte_valid));
                    if (out_data.link_end !== want.link_end)
                        flag_error($sformatf("link_end %b, expected %b",
                                             out_data.link_end, want.link_end));
                    if (out_data.page_done !== want.page_done)
                        flag_error($sformatf("page_done %b, expected %b",
                                             out_data.page_done, want.page_done));
                end
            end
        end
    end

    initial begin
        int random_start;

        // page ends inside a link, on a nonzero last byte
        push_text("<A href=z");
        mark_last();
        // empty page
        push_byte(CH_NUL, 1'b0);
        // spaced anchor, quoted link, top byte value, space terminator, zero marked last
        push_text("< A HrEf=\"");
        push_byte(8'hff, 1'b0);
        push_text(" x>");
        push_byte(CH_NUL, 1'b1);

        // truncated link, the byte after the cut is dropped; a link opens on the last byte
        push_text("<a href=\"");
        repeat (LINK_LEN_LIMIT + 3)
            push_byte(8'($urandom_range(8'h61, 8'h7a)), 1'b0);
        push_text("\"> href=");
        mark_last();

        random_start = page_stim_q.size();
        page_stim_q[$].drain = 1'b1;
        while (page_stim_q.size() < random_start + RANDOM_ITEMS)
            push_page();
        total_items = page_stim_q.size();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (page_stim_q.size() != 0 || in_valid)
            @(posedge clk);
        while (pending_links.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (pending_links.size() != 0)
            flag_error($sformatf("%0d results never arrived", pending_links.size()));
        if (err_count == 0)
            $display("html_anchor_href_extractor verification clean");
        else
            $display("html_anchor_href_extractor verification failed");
        $finish;
    end

endmodule

// ===== html_anchor_href_extractor.f =====
+incdir+rtl
rtl/hahe_pkg.sv
rtl/html_anchor_href_extractor.sv
tb/html_anchor_href_extractor_test.sv
